/* hdl/mi3_pkg.sv */
// Shared types, widths and constants for the 3x3 matrix inverse pipeline.
package mi3_pkg;

	localparam int D_W           = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int THR_W         = 16;
	localparam logic [THR_W-1:0] THR_RESET = 16'd7;

	localparam int PW  = 2 * D_W;       // entry product
	localparam int CW  = 2 * D_W + 1;   // signed cofactor
	localparam int NW  = 2 * D_W;       // cofactor magnitude
	localparam int DTW = 3 * D_W + 1;   // signed determinant
	localparam int MW  = 3 * D_W;       // determinant magnitude

	typedef logic signed [PW-1:0]  prod_t;
	typedef logic signed [CW-1:0]  cof_t;
	typedef logic signed [DTW-1:0] det_t;
	typedef logic [3:0]            idx_t;

	// adjugate entry k = e[p]*e[q] - e[u]*e[v], entries column-major
	localparam idx_t ADJ_TAB [9][4] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
		'{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
	};

	typedef struct packed {
		logic signed [D_W-1:0] a00;
		logic signed [D_W-1:0] a10;
		logic signed [D_W-1:0] a20;
		logic signed [D_W-1:0] a01;
		logic signed [D_W-1:0] a11;
		logic signed [D_W-1:0] a21;
		logic signed [D_W-1:0] a02;
		logic signed [D_W-1:0] a12;
		logic signed [D_W-1:0] a22;
	} mat_in_t;

	typedef struct packed {
		logic signed [D_W-1:0] b00;
		logic signed [D_W-1:0] b10;
		logic signed [D_W-1:0] b20;
		logic signed [D_W-1:0] b01;
		logic signed [D_W-1:0] b11;
		logic signed [D_W-1:0] b21;
		logic signed [D_W-1:0] b02;
		logic signed [D_W-1:0] b12;
		logic signed [D_W-1:0] b22;
		logic                  singular;
	} mat_out_t;

endpackage

/* hdl/mi3_det.sv */
// Cofactor and determinant pipeline, five register stages.
module mi3_det import mi3_pkg::*; (
	input  logic    clk,
	input  logic    en,
	input  mat_in_t mat,
	output cof_t    cof [9],
	output det_t    det
);

	logic signed [D_W-1:0] e [9];
	prod_t pa_s1 [9];
	prod_t pb_s1 [9];
	logic signed [D_W-1:0] col_s1 [3];
	cof_t  cof_s2 [9];
	logic signed [D_W-1:0] col_s2 [3];
	logic signed [2*D_W:0] plo_s3 [3];
	logic signed [2*D_W:0] phi_s3 [3];
	cof_t  cof_s3 [9];
	det_t  term_s4 [3];
	cof_t  cof_s4 [9];
	det_t  det_s5;
	cof_t  cof_s5 [9];

	assign e[0] = mat.a00;
	assign e[1] = mat.a10;
	assign e[2] = mat.a20;
	assign e[3] = mat.a01;
	assign e[4] = mat.a11;
	assign e[5] = mat.a21;
	assign e[6] = mat.a02;
	assign e[7] = mat.a12;
	assign e[8] = mat.a22;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				pa_s1[k] <= PW'(e[ADJ_TAB[k][0]]) * PW'(e[ADJ_TAB[k][1]]);
				pb_s1[k] <= PW'(e[ADJ_TAB[k][2]]) * PW'(e[ADJ_TAB[k][3]]);
			end
			col_s1[0] <= e[0];
			col_s1[1] <= e[3];
			col_s1[2] <= e[6];

			for (int k = 0; k < 9; k++)
				cof_s2[k] <= CW'(pa_s1[k]) - CW'(pb_s1[k]);
			col_s2 <= col_s1;

			// row-0 expansion, cofactor split into low unsigned and high signed halves
			for (int j = 0; j < 3; j++) begin
				plo_s3[j] <= (2*D_W+1)'(col_s2[j]) *
					(2*D_W+1)'($signed({1'b0, cof_s2[j][D_W-1:0]}));
				phi_s3[j] <= (2*D_W+1)'(col_s2[j]) *
					(2*D_W+1)'($signed(cof_s2[j][CW-1:D_W]));
			end
			cof_s3 <= cof_s2;

			for (int j = 0; j < 3; j++)
				term_s4[j] <= (DTW'(phi_s3[j]) <<< D_W) + DTW'(plo_s3[j]);
			cof_s4 <= cof_s3;

			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			cof_s5 <= cof_s4;
		end
	end

	assign cof = cof_s5;
	assign det = det_s5;

endmodule

/* hdl/mi3_div.sv */
// One output lane: restoring divider, one quotient bit per stage, then round and saturate.
module mi3_div import mi3_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [NW-1:0]         cm,
	input  logic                  neg,
	input  logic [MW-1:0]         dm,
	input  logic                  sing,
	output logic signed [D_W-1:0] b
);

	localparam int RW  = ((2*FRAC_BITS > 2*D_W) ? 2*D_W + 2*FRAC_BITS : 4*D_W) + 1;
	localparam int NST = D_W;
	localparam logic [D_W:0]   HALF  = (D_W+1)'(1) << (D_W-1);
	localparam logic [D_W-1:0] Q_MAX = {1'b0, {(D_W-1){1'b1}}};
	localparam logic [D_W-1:0] Q_MIN = {1'b1, {(D_W-1){1'b0}}};

	logic [RW-1:0]  rem_s  [NST+1];
	logic [MW-1:0]  dm_s   [NST+1];
	logic [D_W-1:0] q_s    [NST+1];
	logic           neg_s  [NST+1];
	logic           sing_s [NST+1];
	logic           ovf_s  [NST+1];
	logic [RW-1:0]  num;
	logic           rnd;
	logic [D_W:0]   qr;
	logic [D_W-1:0] res_nxt;
	logic [D_W-1:0] res_s;

	assign num = RW'(cm) << (2*FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num;
			ovf_s[0]  <= num >= (RW'(dm) << D_W);
			dm_s[0]   <= dm;
			q_s[0]    <= '0;
			neg_s[0]  <= neg;
			sing_s[0] <= sing;
		end
	end

	for (genvar i = 0; i < NST; i++) begin : g_bit
		logic [RW-1:0] dsh;
		logic          ge;
		assign dsh = RW'(dm_s[i]) << (NST-1-i);
		assign ge  = rem_s[i] >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? rem_s[i] - dsh : rem_s[i];
				q_s[i+1]    <= {q_s[i][D_W-2:0], ge};
				dm_s[i+1]   <= dm_s[i];
				neg_s[i+1]  <= neg_s[i];
				sing_s[i+1] <= sing_s[i];
				ovf_s[i+1]  <= ovf_s[i];
			end
		end
	end

	// round to nearest, ties away from zero
	assign rnd = (rem_s[NST] << 1) >= RW'(dm_s[NST]);
	assign qr  = {1'b0, q_s[NST]} + (D_W+1)'(rnd);

	always_comb begin
		if (sing_s[NST])
			res_nxt = '0;
		else if (!neg_s[NST])
			res_nxt = (ovf_s[NST] || qr >= HALF) ? Q_MAX : qr[D_W-1:0];
		else
			res_nxt = (ovf_s[NST] || qr > HALF) ? Q_MIN : D_W'(-qr[D_W-1:0]);
	end

	always_ff @(posedge clk) begin
		if (en)
			res_s <= res_nxt;
	end

	assign b = $signed(res_s);

endmodule

/* hdl/matrix_inverse_3x3_top.sv */
// Top level of the 3x3 matrix inverse: handshake, threshold register, stage control.
//
//  channel  | signals                        | moves
//  ---------+--------------------------------+-------------------------------
//  input    | in_valid, in_ready, in_data    | one matrix request
//  output   | out_valid, out_ready, out_data | inverse and singular flag
//  config   | cfg_we, cfg_wdata              | zero threshold write
//
// One matrix per cycle sustained while the output is not stalled.
// The per-bit divider stages in each output lane set the depth.
// Reset clears all stage valids and loads threshold 7; data registers are not reset.
// A stalled output freezes the whole pipeline; in_ready drops only then.
module matrix_inverse_3x3_top import mi3_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  mat_in_t          in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output mat_out_t         out_data,
	input  logic             cfg_we,
	input  logic [THR_W-1:0] cfg_wdata
);

	localparam int LAT  = D_W + 8;
	localparam int DLAT = D_W + 2;

	logic             en;
	logic             vld_s [LAT];
	logic [THR_W-1:0] thr_q;
	cof_t             cof [9];
	det_t             det;
	logic [MW-1:0]    dm_s6;
	logic             dneg_s6;
	logic [NW-1:0]    cm_s6 [9];
	logic             cneg_s6 [9];
	logic             sing;
	logic             sing_s [DLAT];
	logic signed [D_W-1:0] bq [9];

	assign en       = !vld_s[LAT-1] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < LAT; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	mi3_det u_det (
		.clk (clk),
		.en  (en),
		.mat (in_data),
		.cof (cof),
		.det (det)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			dneg_s6 <= det[DTW-1];
			dm_s6   <= det[DTW-1] ? MW'(-det) : MW'(det);
			for (int k = 0; k < 9; k++) begin
				cneg_s6[k] <= cof[k][CW-1];
				cm_s6[k]   <= cof[k][CW-1] ? NW'(-cof[k]) : NW'(cof[k]);
			end
		end
	end

	// singular when |D| < (threshold + 1) * 2^(2F)
	assign sing = dm_s6 < ((MW'(thr_q) + MW'(1)) << (2*FRAC_BITS));

	always_ff @(posedge clk) begin
		if (en) begin
			sing_s[0] <= sing;
			for (int k = 1; k < DLAT; k++)
				sing_s[k] <= sing_s[k-1];
		end
	end

	for (genvar k = 0; k < 9; k++) begin : g_lane
		mi3_div #(
			.FRAC_BITS (FRAC_BITS)
		) u_div (
			.clk  (clk),
			.en   (en),
			.cm   (cm_s6[k]),
			.neg  (cneg_s6[k] ^ dneg_s6),
			.dm   (dm_s6),
			.sing (sing),
			.b    (bq[k])
		);
	end

	assign out_valid         = vld_s[LAT-1];
	assign out_data.b00      = bq[0];
	assign out_data.b10      = bq[1];
	assign out_data.b20      = bq[2];
	assign out_data.b01      = bq[3];
	assign out_data.b11      = bq[4];
	assign out_data.b21      = bq[5];
	assign out_data.b02      = bq[6];
	assign out_data.b12      = bq[7];
	assign out_data.b22      = bq[8];
	assign out_data.singular = sing_s[DLAT-1];

endmodule

/* dv/mi3_checker.sv */
// Checker for the 3x3 matrix inverse: predicts each inverse and compares it.
`timescale 1ns / 1ps
module mi3_checker import mi3_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  mat_in_t          in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  mat_out_t         out_data,
	input  logic             cfg_we,
	input  logic [THR_W-1:0] cfg_wdata,
	output int               fail_count,
	output int               pending
);
	localparam int FB = 16;

	mat_out_t inverse_q[$];
	logic [THR_W-1:0] thr;

	function automatic mat_out_t invert(mat_in_t m, logic [THR_W-1:0] t);
		logic signed [D_W-1:0] e [9];
		logic signed [255:0] adj [9];
		logic signed [255:0] det, dmag, num, quo, rem, bound;
		logic signed [255:0] lim;
		logic [D_W-1:0] val [9];
		mat_out_t r;
		logic neg;
		e = '{m.a00, m.a10, m.a20, m.a01, m.a11, m.a21, m.a02, m.a12, m.a22};
		for (int k = 0; k < 9; k++) begin
			adj[k] = 256'(e[ADJ_TAB[k][0]]) * 256'(e[ADJ_TAB[k][1]])
				- 256'(e[ADJ_TAB[k][2]]) * 256'(e[ADJ_TAB[k][3]]);
		end
		det = 256'(e[0]) * adj[0] + 256'(e[3]) * adj[1] + 256'(e[6]) * adj[2];
		dmag = det < 0 ? -det : det;
		bound = (256'(t) + 1) <<< (2 * FB);
		lim = 256'sd1 <<< (D_W - 1);
		r = '0;
		if (dmag < bound) begin
			r.singular = 1'b1;
			return r;
		end
		for (int k = 0; k < 9; k++) begin
			neg = (adj[k] < 0) != (det < 0);
			num = (adj[k] < 0 ? -adj[k] : adj[k]) <<< (2 * FB);
			quo = num / dmag;
			rem = num % dmag;
			if (2 * rem >= dmag) quo = quo + 1;
			if (!neg) val[k] = quo >= lim ? D_W'(lim - 1) : D_W'(quo);
			else val[k] = quo > lim ? D_W'(lim) : D_W'(-quo);
		end
		r = {val[0], val[1], val[2], val[3], val[4], val[5], val[6], val[7], val[8], 1'b0};
		return r;
	endfunction

	task automatic report(string what, logic [D_W-1:0] got, logic [D_W-1:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial fail_count = 0;
	assign pending = inverse_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr <= THR_RESET;
		end else begin
			if (cfg_we) thr <= cfg_wdata;
			if (in_valid && in_ready) inverse_q.push_back(invert(in_data, thr));
			if (out_valid && out_ready) begin
				if (inverse_q.size() == 0) begin
					report("unexpected result", 0, 0);
				end else begin
					mat_out_t w;
					w = inverse_q.pop_front();
					if (out_data.singular !== w.singular) report("singular", out_data.singular, w.singular);
					if (out_data.b00 !== w.b00) report("b00", out_data.b00, w.b00);
					if (out_data.b10 !== w.b10) report("b10", out_data.b10, w.b10);
					if (out_data.b20 !== w.b20) report("b20", out_data.b20, w.b20);
					if (out_data.b01 !== w.b01) report("b01", out_data.b01, w.b01);
					if (out_data.b11 !== w.b11) report("b11", out_data.b11, w.b11);
					if (out_data.b21 !== w.b21) report("b21", out_data.b21, w.b21);
					if (out_data.b02 !== w.b02) report("b02", out_data.b02, w.b02);
					if (out_data.b12 !== w.b12) report("b12", out_data.b12, w.b12);
					if (out_data.b22 !== w.b22) report("b22", out_data.b22, w.b22);
				end
			end
		end
	end
endmodule

/* dv/matrix_inverse_3x3_top_tb.sv */
// Testbench top for the 3x3 matrix inverse: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module matrix_inverse_3x3_top_tb import mi3_pkg::*;;
	localparam int ONE = 32'h0001_0000;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_ready, out_valid, out_ready = 1'b0;
	mat_in_t in_data = '0;
	mat_out_t out_data;
	logic cfg_we = 1'b0;
	logic [THR_W-1:0] cfg_wdata = '0;
	int fail_count, pending;
	int send_idle = 0, recv_idle = 0;
	int hold_cycles = 0;
	int stall_cnt = 0;

	always #2 clk = ~clk;

	matrix_inverse_3x3_top i_dut (.*);
	mi3_checker i_chk (.*);

	// receiver: random stalls, long hold-offs counted here
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= $urandom_range(99) >= recv_idle;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
		else stall_cnt <= stall_cnt + 1;
		if (stall_cnt > WATCHDOG) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [31:0] rand_entry();
		case ($urandom_range(5))
			0: return $urandom();
			1: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
			2: return $signed($urandom_range(8 * ONE)) - 4 * ONE;
			3: return $signed($urandom_range(512)) - 256;
			default: return $signed($urandom_range(2 * ONE)) - ONE;
		endcase
	endfunction

	// valid stays up between back-to-back requests; it drops only while idling
	task automatic send(mat_in_t m);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= m;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_thr(logic [THR_W-1:0] t);
		cfg_we <= 1'b1;
		cfg_wdata <= t;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_mat();
		mat_in_t m;
		int sel;
		m = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
			rand_entry(), rand_entry(), rand_entry(), rand_entry()};
		sel = $urandom_range(9);
		// sel 0 copies row 1 into row 2 (singular); sel 1 makes a random diagonal matrix
		if (sel == 0) begin
			m.a20 = m.a10; m.a21 = m.a11; m.a22 = m.a12;
		end else if (sel == 1) begin
			m = '0;
			m.a00 = rand_entry(); m.a11 = rand_entry(); m.a22 = rand_entry();
		end
		send(m);
	endtask

	initial begin
		mat_in_t m;
		logic [THR_W-1:0] thr_set [4] = '{16'd0, 16'hffff, 16'd7, 16'd300};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identity, scaled, zero, tiny, extremes, threshold edge, full matrices
		m = '0; m.a00 = ONE; m.a11 = ONE; m.a22 = ONE; send(m);
		m = '0; m.a00 = 2 * ONE; m.a11 = -ONE; m.a22 = ONE / 2; send(m);
		m = '0; send(m);
		m = '0; m.a00 = 1; m.a11 = 1; m.a22 = 1; send(m);
		m = '0; m.a00 = 32'h7fff_ffff; m.a11 = 32'h7fff_ffff; m.a22 = 32'h7fff_ffff; send(m);
		m = '0; m.a00 = 32'h8000_0000; m.a11 = 32'h8000_0000; m.a22 = 32'h8000_0000; send(m);
		m = {9{32'h8000_0000}}; send(m);
		m = {9{32'hffff_ffff}}; send(m);
		m = '0; m.a00 = 32'h0000_0100; m.a11 = 32'h0000_0100; m.a22 = 32'h0000_0100; send(m);
		m = '0; m.a00 = ONE; m.a11 = ONE; m.a22 = 8; send(m);
		m = '0; m.a00 = ONE; m.a11 = ONE; m.a22 = 7; send(m);
		m = {ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE, 10 * ONE};
		send(m);
		m = {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
		send(m);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_thr(thr_set[ph]);
			case (ph)
				0: begin send_idle = 0;  recv_idle = 0;  end
				1: begin send_idle = 81; recv_idle = 0;  end
				2: begin send_idle = 0;  recv_idle = 81; end
				default: begin send_idle = 36; recv_idle = 36; end
			endcase
			if (ph == 0) hold_cycles = 300;
			repeat (400) random_mat();
			drain();
		end
		send_idle = 0; recv_idle = 0;
		write_thr(THR_W'($urandom()));
		repeat (30) random_mat();
		drain();

		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
